@@ hdl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types for the particle seek-target step pipeline.
// ----------------------------------------------------------------------------
package pst_pkg;

	typedef enum logic [2:0] {
		BAND_FAR,
		BAND_MID,
		BAND_NEAR,
		BAND_CLOSE,
		BAND_STOP
	} band_t;

endpackage

@@ hdl/particle_seek_target_step.sv @@
// ----------------------------------------------------------------------------
// particle_seek_target_step
// Moves one 2D particle by its velocity, then pulls the velocity toward the
// target by distance band and damps it.
// ----------------------------------------------------------------------------
// The block takes one particle per clock while the output is not stalled and
// returns one result per particle in order. The pipeline is made up mostly of
// the square root, which settles one root bit per stage, and of the two
// dividers, which settle one quotient bit per stage. A stall on the output
// holds the whole pipeline.
module particle_seek_target_step #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, vel_x, vel_y, goal_x, goal_y (32 bits each, lowest first)
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y (32 bits each, lowest first)
	output logic [127:0] m_axis_tdata
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int K  = W + 1;
	localparam int SW = 2 * K;
	localparam int QB = K + F;
	localparam int XW = (QB + 3 > 34) ? QB + 3 : 34;

	localparam longint unsigned ONE = 64'd1 << F;
	localparam longint unsigned G9 = ((64'd9 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G8 = ((64'd8 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G7 = ((64'd7 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G6 = ((64'd6 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G5 = ((64'd5 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G3 = ((64'd3 << F) + 64'd5) / 64'd10;
	localparam longint unsigned G1 = ((64'd1 << F) + 64'd5) / 64'd10;
	localparam longint unsigned T005 = ((64'd5 << F) + 64'd50) / 64'd100;
	localparam longint unsigned T20 = 64'd20 * ONE;
	localparam longint unsigned T10 = 64'd10 * ONE;
	localparam longint unsigned T5  = 64'd5 * ONE;

	localparam logic [SW-1:0] SQ20  = SW'(T20 * T20);
	localparam logic [SW-1:0] SQ10  = SW'(T10 * T10);
	localparam logic [SW-1:0] SQ5   = SW'(T5 * T5);
	localparam logic [SW-1:0] SQ005 = SW'(T005 * T005);
	localparam logic [F-1:0]  HALF  = F'(ONE >> 1);

	localparam logic signed [XW-1:0] WMAX = XW'((65'sd1 <<< (W - 1)) - 65'sd1);
	localparam logic signed [XW-1:0] WMIN = ~WMAX;

	typedef struct packed {
		logic signed [W-1:0] px;
		logic signed [W-1:0] py;
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic [K-1:0]        mx;
		logic [K-1:0]        my;
		logic                sx;
		logic                sy;
		pst_pkg::band_t      band;
	} item_t;

	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [W-1:0] r;
		if (v > WMAX)
			r = WMAX[W-1:0];
		else if (v < WMIN)
			r = WMIN[W-1:0];
		else
			r = v[W-1:0];
		return r;
	endfunction

	function automatic logic [31:0] out_field(input logic signed [W-1:0] v);
		logic signed [XW-1:0] e;
		e = XW'(v);
		return e[31:0];
	endfunction

	logic en;
	logic v_s12;

	assign en            = !v_s12 || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: take input, saturate to word range
	logic v_s1;
	logic signed [W-1:0] f_s1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_in
		always_ff @(posedge clk) begin
			if (en) begin
				f_s1[i] <= sat_w(XW'($signed(s_axis_tdata[32*i +: 32])));
			end
		end
	end

	// stage 2: advance position
	logic v_s2;
	logic signed [W-1:0] px_s2, py_s2, vx_s2, vy_s2, gx_s2, gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= sat_w(XW'(f_s1[0]) + XW'(f_s1[2]));
			py_s2 <= sat_w(XW'(f_s1[1]) + XW'(f_s1[3]));
			vx_s2 <= f_s1[2];
			vy_s2 <= f_s1[3];
			gx_s2 <= f_s1[4];
			gy_s2 <= f_s1[5];
		end
	end

	// stage 3: difference to target, sign and magnitude
	logic v_s3;
	item_t it_s3;
	logic signed [K-1:0] dx, dy;

	assign dx = K'(gx_s2) - K'(px_s2);
	assign dy = K'(gy_s2) - K'(py_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3.px   <= px_s2;
			it_s3.py   <= py_s2;
			it_s3.vx   <= vx_s2;
			it_s3.vy   <= vy_s2;
			it_s3.sx   <= dx[K-1];
			it_s3.sy   <= dy[K-1];
			it_s3.mx   <= dx[K-1] ? K'(-dx) : K'(dx);
			it_s3.my   <= dy[K-1] ? K'(-dy) : K'(dy);
			it_s3.band <= pst_pkg::BAND_STOP;
		end
	end

	// stage 4: squares
	logic v_s4;
	item_t it_s4;
	logic [SW-2:0] sqx_s4, sqy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4  <= it_s3;
			sqx_s4 <= (SW-1)'(it_s3.mx) * (SW-1)'(it_s3.mx);
			sqy_s4 <= (SW-1)'(it_s3.my) * (SW-1)'(it_s3.my);
		end
	end

	// stage 5: sum of squares
	logic v_s5;
	item_t it_s5;
	logic [SW-1:0] sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s5  <= it_s4;
			sum_s5 <= SW'(sqx_s4) + SW'(sqy_s4);
		end
	end

	// stage 6: band select
	logic v_s6;
	item_t it_s6;
	item_t it_band;
	logic [SW-1:0] sum_s6;
	pst_pkg::band_t band;

	always_comb begin
		priority if (sum_s5 > SQ20)
			band = pst_pkg::BAND_FAR;
		else if (sum_s5 > SQ10)
			band = pst_pkg::BAND_MID;
		else if (sum_s5 > SQ5)
			band = pst_pkg::BAND_NEAR;
		else if (sum_s5 > SQ005)
			band = pst_pkg::BAND_CLOSE;
		else
			band = pst_pkg::BAND_STOP;
	end

	always_comb begin
		it_band      = it_s5;
		it_band.band = band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s6  <= it_band;
			sum_s6 <= sum_s5;
		end
	end

	// stage 7: square root, one root bit per stage
	logic          v_s7    [K+1];
	item_t         it_s7   [K+1];
	logic [K-1:0]  root_s7 [K+1];
	logic [K:0]    rem_s7  [K+1];
	logic [SW-1:0] rad_s7  [K+1];

	assign v_s7[0]    = v_s6;
	assign it_s7[0]   = it_s6;
	assign root_s7[0] = '0;
	assign rem_s7[0]  = '0;
	assign rad_s7[0]  = sum_s6;

	for (genvar r = 0; r < K; r++) begin : g_sqrt
		logic [K+2:0] t;
		logic [K+2:0] trial;
		logic         take;

		assign t     = {rem_s7[r], rad_s7[r][SW-1 -: 2]};
		assign trial = {1'b0, root_s7[r], 2'b01};
		assign take  = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s7[r+1] <= 1'b0;
			end else if (en) begin
				v_s7[r+1] <= v_s7[r];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s7[r+1]   <= it_s7[r];
				rad_s7[r+1]  <= rad_s7[r] << 2;
				root_s7[r+1] <= {root_s7[r][K-2:0], take};
				rem_s7[r+1]  <= take ? (K+1)'(t - trial) : t[K:0];
			end
		end
	end

	// stage 8: divisor and gain numerators
	logic v_s8;
	item_t it_s8;
	logic [K-1:0]  dist_s8;
	logic [QB-1:0] nx_s8, ny_s8;
	logic [F-1:0]  gain;

	always_comb begin
		unique case (it_s7[K].band)
			pst_pkg::BAND_FAR:   gain = F'(G9);
			pst_pkg::BAND_MID:   gain = F'(G6);
			pst_pkg::BAND_NEAR:  gain = F'(G3);
			pst_pkg::BAND_CLOSE: gain = F'(G1);
			default:             gain = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7[K];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s8   <= it_s7[K];
			dist_s8 <= (root_s7[K] == '0) ? K'(1) : root_s7[K];
			nx_s8   <= QB'(it_s7[K].mx) * QB'(gain);
			ny_s8   <= QB'(it_s7[K].my) * QB'(gain);
		end
	end

	// stage 9: two restoring dividers, one quotient bit per stage
	logic          v_s9    [QB+1];
	item_t         it_s9   [QB+1];
	logic [K-1:0]  dist_s9 [QB+1];
	logic [QB-1:0] nx_s9   [QB+1];
	logic [QB-1:0] ny_s9   [QB+1];
	logic [K-1:0]  rx_s9   [QB+1];
	logic [K-1:0]  ry_s9   [QB+1];
	logic [QB-1:0] qx_s9   [QB+1];
	logic [QB-1:0] qy_s9   [QB+1];

	assign v_s9[0]    = v_s8;
	assign it_s9[0]   = it_s8;
	assign dist_s9[0] = dist_s8;
	assign nx_s9[0]   = nx_s8;
	assign ny_s9[0]   = ny_s8;
	assign rx_s9[0]   = '0;
	assign ry_s9[0]   = '0;
	assign qx_s9[0]   = '0;
	assign qy_s9[0]   = '0;

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [K:0] tx, ty;
		logic       kx, ky;

		assign tx = {rx_s9[j], nx_s9[j][QB-1]};
		assign ty = {ry_s9[j], ny_s9[j][QB-1]};
		assign kx = tx >= {1'b0, dist_s9[j]};
		assign ky = ty >= {1'b0, dist_s9[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s9[j+1] <= 1'b0;
			end else if (en) begin
				v_s9[j+1] <= v_s9[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s9[j+1]   <= it_s9[j];
				dist_s9[j+1] <= dist_s9[j];
				nx_s9[j+1]   <= nx_s9[j] << 1;
				ny_s9[j+1]   <= ny_s9[j] << 1;
				rx_s9[j+1]   <= kx ? K'(tx - {1'b0, dist_s9[j]}) : tx[K-1:0];
				ry_s9[j+1]   <= ky ? K'(ty - {1'b0, dist_s9[j]}) : ty[K-1:0];
				qx_s9[j+1]   <= {qx_s9[j][QB-2:0], kx};
				qy_s9[j+1]   <= {qy_s9[j][QB-2:0], ky};
			end
		end
	end

	// stage 10: add gain term
	logic v_s10;
	item_t it_s10;
	item_t it_pull;
	logic signed [XW-1:0] gx_t, gy_t;

	assign gx_t = it_s9[QB].sx ? -XW'(qx_s9[QB]) : XW'(qx_s9[QB]);
	assign gy_t = it_s9[QB].sy ? -XW'(qy_s9[QB]) : XW'(qy_s9[QB]);

	always_comb begin
		it_pull    = it_s9[QB];
		it_pull.vx = sat_w(XW'(it_s9[QB].vx) + gx_t);
		it_pull.vy = sat_w(XW'(it_s9[QB].vy) + gy_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s10 <= it_pull;
		end
	end

	// stage 11: damping product
	logic v_s11;
	item_t it_s11;
	logic [W+F-1:0] dpx_s11, dpy_s11;
	logic [F-1:0] fac;
	logic [W-1:0] avx, avy;

	always_comb begin
		unique case (it_s10.band)
			pst_pkg::BAND_FAR:   fac = F'(G9);
			pst_pkg::BAND_MID:   fac = F'(G8);
			pst_pkg::BAND_NEAR:  fac = F'(G7);
			pst_pkg::BAND_CLOSE: fac = F'(G5);
			default:             fac = F'(G1);
		endcase
	end

	assign avx = it_s10.vx[W-1] ? W'(-it_s10.vx) : W'(it_s10.vx);
	assign avy = it_s10.vy[W-1] ? W'(-it_s10.vy) : W'(it_s10.vy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s11  <= it_s10;
			dpx_s11 <= (W+F)'(avx) * (W+F)'(fac);
			dpy_s11 <= (W+F)'(avy) * (W+F)'(fac);
		end
	end

	// stage 12: round, restore sign, output register
	logic [W+F:0] rx, ry;
	logic signed [XW-1:0] mx_t, my_t;
	logic signed [W-1:0] nvx_s12, nvy_s12, npx_s12, npy_s12;

	assign rx   = (W+F+1)'(dpx_s11) + (W+F+1)'(HALF);
	assign ry   = (W+F+1)'(dpy_s11) + (W+F+1)'(HALF);
	assign mx_t = XW'(rx[W+F:F]);
	assign my_t = XW'(ry[W+F:F]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			npx_s12 <= it_s11.px;
			npy_s12 <= it_s11.py;
			nvx_s12 <= sat_w(it_s11.vx[W-1] ? -mx_t : mx_t);
			nvy_s12 <= sat_w(it_s11.vy[W-1] ? -my_t : my_t);
		end
	end

	assign m_axis_tvalid = v_s12;
	assign m_axis_tdata  = {out_field(nvy_s12), out_field(nvx_s12),
		out_field(npy_s12), out_field(npx_s12)};

endmodule
